/* rtl/qvr_pkg.sv */
// Shared width constants for the quaternion vector rotator.
`default_nettype none
package qvr_pkg;
	// Extra bits over 2*W for a rotation matrix entry or the squared norm
	localparam int unsigned ENTRY_EXTRA = 2;
	// Extra bits over 3*W for a row sum of the matrix-vector product
	localparam int unsigned SUM_EXTRA = 4;
	// Extra bits over 3*W for the divider dividend and remainder
	localparam int unsigned DIV_EXTRA = 6;
endpackage
`default_nettype wire

/* rtl/qvr_matrix.sv */
// Unnormalized rotation matrix and squared norm from a quaternion, two stages.
`default_nettype none
module qvr_matrix import qvr_pkg::*; #(
	parameter int unsigned W = 16
) (
	input  wire                          clk,
	input  wire  signed [W-1:0]          quat_w,
	input  wire  signed [W-1:0]          quat_x,
	input  wire  signed [W-1:0]          quat_y,
	input  wire  signed [W-1:0]          quat_z,
	output logic signed [2*W+ENTRY_EXTRA-1:0] mat_s2 [9],
	output logic signed [2*W+ENTRY_EXTRA-1:0] norm_s2
);
	localparam int unsigned EW = 2*W + ENTRY_EXTRA;

	logic signed [2*W-1:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [2*W-1:0] xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;

	// stage 1: the ten component products
	always_ff @(posedge clk) begin
		ww_s1 <= quat_w * quat_w;
		xx_s1 <= quat_x * quat_x;
		yy_s1 <= quat_y * quat_y;
		zz_s1 <= quat_z * quat_z;
		xy_s1 <= quat_x * quat_y;
		wz_s1 <= quat_w * quat_z;
		xz_s1 <= quat_x * quat_z;
		wy_s1 <= quat_w * quat_y;
		yz_s1 <= quat_y * quat_z;
		wx_s1 <= quat_w * quat_x;
	end

	// stage 2: matrix entries, off-diagonal doubled
	always_ff @(posedge clk) begin
		mat_s2[0] <= EW'(ww_s1) + EW'(xx_s1) - EW'(yy_s1) - EW'(zz_s1);
		mat_s2[1] <= (EW'(xy_s1) - EW'(wz_s1)) <<< 1;
		mat_s2[2] <= (EW'(xz_s1) + EW'(wy_s1)) <<< 1;
		mat_s2[3] <= (EW'(xy_s1) + EW'(wz_s1)) <<< 1;
		mat_s2[4] <= EW'(ww_s1) - EW'(xx_s1) + EW'(yy_s1) - EW'(zz_s1);
		mat_s2[5] <= (EW'(yz_s1) - EW'(wx_s1)) <<< 1;
		mat_s2[6] <= (EW'(xz_s1) - EW'(wy_s1)) <<< 1;
		mat_s2[7] <= (EW'(yz_s1) + EW'(wx_s1)) <<< 1;
		mat_s2[8] <= EW'(ww_s1) - EW'(xx_s1) - EW'(yy_s1) + EW'(zz_s1);
		norm_s2   <= EW'(ww_s1) + EW'(xx_s1) + EW'(yy_s1) + EW'(zz_s1);
	end
endmodule
`default_nettype wire

/* rtl/qvr_mulacc.sv */
// Matrix times vector: products in one stage, row sums in the next.
`default_nettype none
module qvr_mulacc import qvr_pkg::*; #(
	parameter int unsigned W = 16
) (
	input  wire                               clk,
	input  wire  signed [2*W+ENTRY_EXTRA-1:0] mat [9],
	input  wire  signed [2*W+ENTRY_EXTRA-1:0] norm,
	input  wire  signed [W-1:0]               vec_x,
	input  wire  signed [W-1:0]               vec_y,
	input  wire  signed [W-1:0]               vec_z,
	output logic signed [3*W+SUM_EXTRA-1:0]   acc_s4 [3],
	output logic signed [2*W+ENTRY_EXTRA-1:0] norm_s4
);
	localparam int unsigned EW = 2*W + ENTRY_EXTRA;
	localparam int unsigned PW = EW + W;
	localparam int unsigned SW = 3*W + SUM_EXTRA;

	logic signed [PW-1:0] prod_s3 [9];
	logic signed [EW-1:0] norm_s3;

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			prod_s3[3*r]   <= PW'(mat[3*r])   * PW'(vec_x);
			prod_s3[3*r+1] <= PW'(mat[3*r+1]) * PW'(vec_y);
			prod_s3[3*r+2] <= PW'(mat[3*r+2]) * PW'(vec_z);
		end
		norm_s3 <= norm;
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			acc_s4[r] <= SW'(prod_s3[3*r]) + SW'(prod_s3[3*r+1]) + SW'(prod_s3[3*r+2]);
		end
		norm_s4 <= norm_s3;
	end
endmodule
`default_nettype wire

/* rtl/qvr_div.sv */
// Pipelined restoring divider: round(num/norm) half away from zero, saturated.
`default_nettype none
module qvr_div import qvr_pkg::*; #(
	parameter int unsigned W = 16
) (
	input  wire                               clk,
	input  wire  signed [3*W+SUM_EXTRA-1:0]   num,
	input  wire  signed [2*W+ENTRY_EXTRA-1:0] norm,
	output logic signed [W-1:0]               res
);
	localparam int unsigned SW = 3*W + SUM_EXTRA;
	localparam int unsigned DW = 3*W + DIV_EXTRA;
	localparam int unsigned QW = W - 1;

	logic signed [SW-1:0] mag;
	logic [DW-1:0]        dvd_sa, den_sa;
	logic                 neg_sa;

	// rounding folded in: q = floor((2|num| + n) / 2n)
	always_comb begin
		mag = num[SW-1] ? -num : num;
	end

	always_ff @(posedge clk) begin
		neg_sa <= num[SW-1];
		dvd_sa <= (DW'($unsigned(mag)) << 1) + DW'($unsigned(norm));
		den_sa <= DW'($unsigned(norm)) << 1;
	end

	logic [DW-1:0] rem_s [W];
	logic [DW-1:0] den_s [W];
	logic [QW-1:0] quo_s [W];
	logic          sat_s [W];
	logic          neg_s [W];

	// saturation check: quotient would reach 2^(W-1)
	always_ff @(posedge clk) begin
		rem_s[0] <= dvd_sa;
		den_s[0] <= den_sa;
		quo_s[0] <= '0;
		sat_s[0] <= dvd_sa >= (den_sa << QW);
		neg_s[0] <= neg_sa;
	end

	// one quotient bit per stage, MSB first
	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [DW-1:0] trial;
		logic          hit;
		always_comb begin
			trial = den_s[i] << (QW - 1 - i);
			hit   = rem_s[i] >= trial;
		end
		always_ff @(posedge clk) begin
			rem_s[i+1] <= hit ? rem_s[i] - trial : rem_s[i];
			quo_s[i+1] <= (quo_s[i] << 1) | QW'(hit);
			den_s[i+1] <= den_s[i];
			sat_s[i+1] <= sat_s[i];
			neg_s[i+1] <= neg_s[i];
		end
	end

	logic signed [W-1:0] qval;

	always_comb begin
		qval = $signed({1'b0, quo_s[QW]});
		if (sat_s[QW]) begin
			res = neg_s[QW] ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
		end else begin
			res = neg_s[QW] ? -qval : qval;
		end
	end
endmodule
`default_nettype wire

/* rtl/quaternion_vector_rotate.sv */
// Top level: rotate a 3D vector by a quaternion of any nonzero norm, fully pipelined.
//
//  channel   handshake        beat contents
//  -------   --------------   -------------------------------------------
//  command   start / busy     quat_w, quat_x, quat_y, quat_z, vec_x..vec_z
//  result    done (strobe)    rot_x, rot_y, rot_z, degenerate
//
// A beat is taken on every clock edge where start is high; busy is always low.
// Stages in order: qvr_matrix builds the matrix, qvr_mulacc multiplies it by the
// vector, and the divider runs its setup registers and then a stage per quotient
// bit, followed by one output register.
// One beat per cycle sustained; every stage is a free-running register.
// arst_n clears only the valid chain; data registers carry no reset.
// The result receiver cannot stall: done lasts one cycle per beat.
`default_nettype none
module quaternion_vector_rotate import qvr_pkg::*; #(
	parameter int unsigned COMPONENT_WIDTH = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire  signed [COMPONENT_WIDTH-1:0] quat_w,
	input  wire  signed [COMPONENT_WIDTH-1:0] quat_x,
	input  wire  signed [COMPONENT_WIDTH-1:0] quat_y,
	input  wire  signed [COMPONENT_WIDTH-1:0] quat_z,
	input  wire  signed [COMPONENT_WIDTH-1:0] vec_x,
	input  wire  signed [COMPONENT_WIDTH-1:0] vec_y,
	input  wire  signed [COMPONENT_WIDTH-1:0] vec_z,
	output logic                             done,
	output logic signed [COMPONENT_WIDTH-1:0] rot_x,
	output logic signed [COMPONENT_WIDTH-1:0] rot_y,
	output logic signed [COMPONENT_WIDTH-1:0] rot_z,
	output logic                             degenerate
);
	localparam int unsigned W  = COMPONENT_WIDTH;
	localparam int unsigned EW = 2*W + ENTRY_EXTRA;
	localparam int unsigned SW = 3*W + SUM_EXTRA;
	// cycles from accept to divider output
	localparam int unsigned DL = W + 5;

	// pipeline never stalls
	assign busy = 1'b0;

	// side delay line: valid, zero-quaternion flag and the input vector
	logic                vld_q [DL];
	logic                deg_q [DL];
	logic signed [W-1:0] vx_q  [DL];
	logic signed [W-1:0] vy_q  [DL];
	logic signed [W-1:0] vz_q  [DL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DL; i++) vld_q[i] <= 1'b0;
		end else begin
			vld_q[0] <= start;
			for (int i = 1; i < DL; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		deg_q[0] <= (quat_w == '0) && (quat_x == '0) && (quat_y == '0) && (quat_z == '0);
		vx_q[0]  <= vec_x;
		vy_q[0]  <= vec_y;
		vz_q[0]  <= vec_z;
		for (int i = 1; i < DL; i++) begin
			deg_q[i] <= deg_q[i-1];
			vx_q[i]  <= vx_q[i-1];
			vy_q[i]  <= vy_q[i-1];
			vz_q[i]  <= vz_q[i-1];
		end
	end

	logic signed [EW-1:0] mat [9];
	logic signed [EW-1:0] norm_m;
	logic signed [SW-1:0] acc [3];
	logic signed [EW-1:0] norm_a;
	logic signed [W-1:0]  res [3];

	qvr_matrix #(.W(W)) u_matrix (
		.clk     (clk),
		.quat_w  (quat_w),
		.quat_x  (quat_x),
		.quat_y  (quat_y),
		.quat_z  (quat_z),
		.mat_s2  (mat),
		.norm_s2 (norm_m)
	);

	// vector taken from the second register of the delay line to meet the matrix
	qvr_mulacc #(.W(W)) u_mulacc (
		.clk     (clk),
		.mat     (mat),
		.norm    (norm_m),
		.vec_x   (vx_q[1]),
		.vec_y   (vy_q[1]),
		.vec_z   (vz_q[1]),
		.acc_s4  (acc),
		.norm_s4 (norm_a)
	);

	for (genvar c = 0; c < 3; c++) begin : g_div
		qvr_div #(.W(W)) u_div (
			.clk  (clk),
			.num  (acc[c]),
			.norm (norm_a),
			.res  (res[c])
		);
	end

	// output register; zero quaternion passes the vector through
	logic                done_q;
	logic                deg_out_q;
	logic signed [W-1:0] rx_q, ry_q, rz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_q[DL-1];
		end
	end

	always_ff @(posedge clk) begin
		deg_out_q <= deg_q[DL-1];
		rx_q      <= deg_q[DL-1] ? vx_q[DL-1] : res[0];
		ry_q      <= deg_q[DL-1] ? vy_q[DL-1] : res[1];
		rz_q      <= deg_q[DL-1] ? vz_q[DL-1] : res[2];
	end

	assign done       = done_q;
	assign degenerate = deg_out_q;
	assign rot_x      = rx_q;
	assign rot_y      = ry_q;
	assign rot_z      = rz_q;
endmodule
`default_nettype wire

/* tb/quaternion_vector_rotate_tb.sv */
// Self-checking testbench for the quaternion vector rotator.
`timescale 1ns / 100ps
`default_nettype none
module quaternion_vector_rotate_tb;
	import qvr_pkg::*;

	localparam int unsigned CW = 16;
	localparam int LATENCY = CW + 6;
	localparam int DRAIN_CYCLES = 4 * LATENCY;
	localparam int RANDOM_BEATS = 1630;
	localparam int QUIET_TAIL = 200;	// last beats sent with no idling

	typedef logic signed [CW-1:0] comp_t;

	typedef struct {
		comp_t qw, qx, qy, qz;
		comp_t vx, vy, vz;
		bit    hold;	// wait for every result before sending this beat
	} rot_cmd_t;

	typedef struct {
		comp_t rx, ry, rz;
		logic  degen;
	} rot_res_t;

	logic  clk;
	logic  arst_n;
	logic  start;
	wire   busy;
	comp_t quat_w, quat_x, quat_y, quat_z;
	comp_t vec_x, vec_y, vec_z;
	wire   done;
	wire signed [CW-1:0] rot_x, rot_y, rot_z;
	wire   degenerate;

	rot_cmd_t cmd_queue[$];
	rot_res_t rot_expect[$];
	int       errors;
	int       gap_left;

	quaternion_vector_rotate #(.COMPONENT_WIDTH(CW)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.done(done), .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
		.degenerate(degenerate)
	);

	initial begin
		clk = 1'b0;
	end
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Divide one matrix row by the squared norm: round half away from zero,
	// then clamp to the signed component range.
	function automatic comp_t div_round_sat(longint num, longint norm);
		longint mag;
		longint quo;
		bit     neg;
		neg = num < 0;
		mag = neg ? -num : num;
		quo = (2 * mag + norm) / (2 * norm);
		if (quo >= (longint'(1) << (CW - 1)))
			return neg ? comp_t'(-(longint'(1) << (CW - 1)))
				: comp_t'((longint'(1) << (CW - 1)) - 1);
		return neg ? comp_t'(-quo) : comp_t'(quo);
	endfunction

	// Expected rotation: R(q) v / |q|^2 with the unnormalized Hamilton matrix.
	// All products stay well inside 64 bits at 16-bit components.
	function automatic rot_res_t predict_rotation(rot_cmd_t c);
		longint w, x, y, z, vx, vy, vz;
		longint norm, ax, ay, az;
		rot_res_t r;
		w = c.qw; x = c.qx; y = c.qy; z = c.qz;
		vx = c.vx; vy = c.vy; vz = c.vz;
		if (w == 0 && x == 0 && y == 0 && z == 0) begin
			// zero quaternion falls back to identity and flags it
			r.rx = c.vx; r.ry = c.vy; r.rz = c.vz; r.degen = 1'b1;
			return r;
		end
		norm = w*w + x*x + y*y + z*z;
		ax = (w*w + x*x - y*y - z*z) * vx + 2*(x*y - w*z) * vy + 2*(x*z + w*y) * vz;
		ay = 2*(x*y + w*z) * vx + (w*w - x*x + y*y - z*z) * vy + 2*(y*z - w*x) * vz;
		az = 2*(x*z - w*y) * vx + 2*(y*z + w*x) * vy + (w*w - x*x - y*y + z*z) * vz;
		r.rx = div_round_sat(ax, norm);
		r.ry = div_round_sat(ay, norm);
		r.rz = div_round_sat(az, norm);
		r.degen = 1'b0;
		return r;
	endfunction

	function automatic rot_cmd_t make_cmd(int qw, int qx, int qy, int qz,
			int vx, int vy, int vz);
		rot_cmd_t c;
		c.qw = comp_t'(qw); c.qx = comp_t'(qx); c.qy = comp_t'(qy); c.qz = comp_t'(qz);
		c.vx = comp_t'(vx); c.vy = comp_t'(vy); c.vz = comp_t'(vz);
		c.hold = 1'b0;
		return c;
	endfunction

	// One random component: full range, a single set bit, a single clear bit,
	// an extreme, or a small magnitude so that rotations stay mostly in range.
	function automatic comp_t rand_comp();
		case ($urandom_range(0, 5))
			0: return comp_t'(1 << $urandom_range(0, CW - 1));
			1: return $urandom_range(0, 1) ? comp_t'(16'h7fff) : comp_t'(16'h8000);
			2: return comp_t'($signed($urandom_range(0, 1024)) - 512);
			3: return comp_t'(16'hffff ^ (1 << $urandom_range(0, CW - 1)));
			default: return comp_t'($urandom);
		endcase
	endfunction

	// Driver: start holds one beat from the head of the queue; the head is
	// dropped once it is taken. Random idle bursts except near the end.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				rot_expect.push_back(predict_rotation(cmd_queue[0]));
				void'(cmd_queue.pop_front());
			end
			if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (cmd_queue.size() == 0) begin
				start <= 1'b0;
			end else if (cmd_queue[0].hold && (rot_expect.size() != 0 || (start && !busy))) begin
				start <= 1'b0;
			end else if (cmd_queue.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
				start <= 1'b0;
				gap_left <= $urandom_range(0, 15);
			end else begin
				start <= 1'b1;
				cmd_queue[0].hold = 1'b0;
				quat_w <= cmd_queue[0].qw;
				quat_x <= cmd_queue[0].qx;
				quat_y <= cmd_queue[0].qy;
				quat_z <= cmd_queue[0].qz;
				vec_x <= cmd_queue[0].vx;
				vec_y <= cmd_queue[0].vy;
				vec_z <= cmd_queue[0].vz;
			end
		end
	end

	// Monitor: every done beat must match the oldest outstanding prediction.
	always @(posedge clk) begin
		rot_res_t e;
		if (arst_n && done) begin
			if (rot_expect.size() == 0) begin
				$display("%0t: unexpected result beat rot=(%0d,%0d,%0d) degenerate=%0b",
					$time, rot_x, rot_y, rot_z, degenerate);
				errors++;
			end else begin
				e = rot_expect.pop_front();
				if (rot_x !== e.rx) begin
					$display("%0t: rot_x expected %0d actual %0d", $time, e.rx, rot_x);
					errors++;
				end
				if (rot_y !== e.ry) begin
					$display("%0t: rot_y expected %0d actual %0d", $time, e.ry, rot_y);
					errors++;
				end
				if (rot_z !== e.rz) begin
					$display("%0t: rot_z expected %0d actual %0d", $time, e.rz, rot_z);
					errors++;
				end
				if (degenerate !== e.degen) begin
					$display("%0t: degenerate expected %0b actual %0b",
						$time, e.degen, degenerate);
					errors++;
				end
			end
		end
	end

	initial begin
		rot_cmd_t c;
		int i;
		errors = 0;
		start = 1'b0;
		quat_w = '0; quat_x = '0; quat_y = '0; quat_z = '0;
		vec_x = '0; vec_y = '0; vec_z = '0;
		arst_n = 1'b0;

		// Directed: zero quaternion with extreme vectors, identity, unit axes,
		// half turns, non-unit scale, saturation and extreme components.
		cmd_queue.push_back(make_cmd(0, 0, 0, 0, 32767, -32768, 0));
		cmd_queue.push_back(make_cmd(0, 0, 0, 0, -32768, 32767, -1));
		cmd_queue.push_back(make_cmd(8192, 0, 0, 0, 256, -512, 32767));
		cmd_queue.push_back(make_cmd(0, 8192, 0, 0, 256, 512, 768));
		cmd_queue.push_back(make_cmd(0, 0, 8192, 0, 256, 512, 768));
		cmd_queue.push_back(make_cmd(0, 0, 0, 8192, 256, 512, 768));
		cmd_queue.push_back(make_cmd(5793, 0, 0, 5793, 256, 0, 0));
		cmd_queue.push_back(make_cmd(5793, 5793, 0, 0, 0, 256, 0));
		cmd_queue.push_back(make_cmd(1, 0, 0, 0, 100, 200, 300));
		cmd_queue.push_back(make_cmd(0, 0, 0, -1, 100, 200, 300));
		cmd_queue.push_back(make_cmd(1, 1, 0, 0, 32767, 32767, 32767));
		cmd_queue.push_back(make_cmd(1, 1, 1, 1, -32768, -32768, -32768));
		cmd_queue.push_back(make_cmd(1, 1, 1, 1, 32767, -32768, 32767));
		cmd_queue.push_back(make_cmd(32767, 32767, 32767, 32767, 32767, 32767, 32767));
		cmd_queue.push_back(make_cmd(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
		cmd_queue.push_back(make_cmd(-32768, 32767, -32768, 32767, 1, -1, 1));
		cmd_queue.push_back(make_cmd(4096, -7000, 1234, 32767, 0, 0, 0));
		cmd_queue.push_back(make_cmd(3, 1, 0, 0, 1, 1, 1));	// norm of ten, no rounding ties
		cmd_queue.push_back(make_cmd(1, 0, 0, 1, -3, 5, 0));
		cmd_queue.push_back(make_cmd(-8192, 0, 0, 0, -1, 0, 1));

		for (i = 0; i < RANDOM_BEATS; i++) begin
			c = make_cmd(0, 0, 0, 0, 0, 0, 0);
			if ($urandom_range(0, 19) != 0) begin
				c.qw = rand_comp(); c.qx = rand_comp();
				c.qy = rand_comp(); c.qz = rand_comp();
			end
			c.vx = rand_comp(); c.vy = rand_comp(); c.vz = rand_comp();
			c.hold = (i == RANDOM_BEATS / 3) || (i == (2 * RANDOM_BEATS) / 3);
			cmd_queue.push_back(c);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		wait (cmd_queue.size() == 0 && rot_expect.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire
